// ===== sv/ssdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment serial display driver package
// Shared types, protocol constants and the digit-to-segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdd_pkg;

  localparam int NUMBER_W = 15;

  // Fixed command bytes of the two-wire display protocol.
  localparam logic [7:0] CMD_DATA_AUTO_INC = 8'h40;
  localparam logic [7:0] CMD_ADDR_FIRST    = 8'hc0;
  localparam logic [7:0] BRIGHTNESS_RESET  = 8'd143;

  // A byte is 24 bit ticks followed by two closing clock ticks.
  localparam logic [4:0] BYTE_BIT_TICKS = 5'd24;

  // Reciprocal of ten for values below 2**15: q = (n * 52429) >> 19.
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [NUMBER_W-1:0] number;
  } item_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [NUMBER_W-1:0] number;
  } conv_req_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0: pat = 8'h3f;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5b;
      4'd3: pat = 8'h4f;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6d;
      4'd6: pat = 8'h7d;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7f;
      4'd9: pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ssdd_front.sv =====
// ----------------------------------------------------------------------------
// Input front end
// Accepts input transactions, tags them as tick or load, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_command,
  input  wire logic [ssdd_pkg::NUMBER_W-1:0] in_number,
  output logic                               item_valid,
  output ssdd_pkg::item_t                    item,
  input  wire logic                          item_ready
);

  ssdd_pkg::item_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;
  ssdd_pkg::item_t new_item;

  assign in_full    = (count_r == 2'd2);
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  assign do_push = in_push && !in_full;
  assign do_pop  = item_valid && item_ready;

  always_comb begin
    new_item.op     = in_command ? ssdd_pkg::OP_LOAD : ssdd_pkg::OP_TICK;
    new_item.number = in_number;
    wr_ptr_nxt      = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt      = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt       = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssdd_digits.sv =====
// ----------------------------------------------------------------------------
// Decimal digit converter
// Splits a number into decimal digits, one digit per cycle, and stores
// the segment pattern of each digit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_digits #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ssdd_pkg::conv_req_t          req,
  output logic [DIGIT_COUNT-1:0][7:0]       seg
);

  localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [DIGIT_COUNT-1:0][7:0]       seg_r;
  logic [ssdd_pkg::NUMBER_W-1:0]     n_r;
  logic [DW-1:0]                     cnt_r;
  logic                              active_r;
  logic [ssdd_pkg::NUMBER_W+15:0]    prod;
  logic [11:0]                       quot;
  logic [ssdd_pkg::NUMBER_W-1:0]     times_ten;
  logic [ssdd_pkg::NUMBER_W-1:0]     rem_full;

  assign seg = seg_r;

  // Quotient by ten through the reciprocal, remainder by subtraction.
  always_comb begin
    prod      = (ssdd_pkg::NUMBER_W+16)'(n_r) * (ssdd_pkg::NUMBER_W+16)'(ssdd_pkg::RECIP_TEN);
    quot      = prod[ssdd_pkg::RECIP_SHIFT+11:ssdd_pkg::RECIP_SHIFT];
    times_ten = ssdd_pkg::NUMBER_W'({quot, 3'b000}) + ssdd_pkg::NUMBER_W'({quot, 1'b0});
    rem_full  = n_r - times_ten;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      seg_r    <= '0;
    end else if (req.start) begin
      active_r <= 1'b1;
      n_r      <= req.number;
      cnt_r    <= DW'(DIGIT_COUNT - 1);
    end else if (active_r) begin
      seg_r[cnt_r] <= ssdd_pkg::seg_pattern(rem_full[3:0]);
      n_r          <= ssdd_pkg::NUMBER_W'(quot);
      if (cnt_r == '0) begin
        active_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - DW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssdd_back.sv =====
// ----------------------------------------------------------------------------
// Pin sequencer and result queue
// Steps the two-wire start/byte/stop sequence one tick at a time and
// queues one pin-state result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_back #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         item_valid,
  input  wire ssdd_pkg::item_t              item,
  output logic                              item_ready,
  input  wire logic [7:0]                   brightness,
  input  wire logic [DIGIT_COUNT-1:0][7:0]  seg,
  output ssdd_pkg::conv_req_t               conv_req,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output ssdd_pkg::result_t                 result
);

  localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_A,
    S_BRIGHT,
    S_START_B,
    S_CMD_DATA,
    S_STOP_A,
    S_START_C,
    S_CMD_ADDR,
    S_DIGITS,
    S_STOP_B
  } seq_state_t;

  seq_state_t    st_r, st_nxt;
  logic [4:0]    tick_r, tick_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [2:0]    bit_idx_r, bit_idx_nxt;
  logic [DW-1:0] dig_r, dig_nxt;
  logic          clk_lvl_r, clk_lvl_nxt;
  logic          dat_lvl_r, dat_lvl_nxt;
  logic [7:0]    byte_val;
  logic          take;
  logic          seg_done;
  seq_state_t    follow;

  ssdd_pkg::result_t res_q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;
  logic              res_pop;
  ssdd_pkg::result_t new_res;

  assign item_ready = (count_r != 2'd2);
  assign take       = item_valid && item_ready;
  assign out_empty  = (count_r == 2'd0);
  assign result     = res_q_r[rd_ptr_r];
  assign res_pop    = out_pop && !out_empty;

  // Byte on the wire in each byte-carrying state.
  always_comb begin
    case (st_r)
      S_BRIGHT:   byte_val = brightness;
      S_CMD_DATA: byte_val = ssdd_pkg::CMD_DATA_AUTO_INC;
      S_CMD_ADDR: byte_val = ssdd_pkg::CMD_ADDR_FIRST;
      S_DIGITS:   byte_val = seg[dig_r];
      default:    byte_val = 8'h00;
    endcase
  end

  // Segment that comes after the current one once it completes.
  always_comb begin
    seg_done = (dig_r == DW'(DIGIT_COUNT - 1));
    unique case (st_r)
      S_START_A:  follow = S_BRIGHT;
      S_BRIGHT:   follow = S_START_B;
      S_START_B:  follow = S_CMD_DATA;
      S_CMD_DATA: follow = S_STOP_A;
      S_STOP_A:   follow = S_START_C;
      S_START_C:  follow = S_CMD_ADDR;
      S_CMD_ADDR: follow = S_DIGITS;
      S_DIGITS:   follow = seg_done ? S_STOP_B : S_DIGITS;
      S_STOP_B:   follow = S_IDLE;
      default:    follow = S_IDLE;
    endcase
  end

  always_comb begin
    st_nxt          = st_r;
    tick_nxt        = tick_r;
    sub_nxt         = sub_r;
    bit_idx_nxt     = bit_idx_r;
    dig_nxt         = dig_r;
    clk_lvl_nxt     = clk_lvl_r;
    dat_lvl_nxt     = dat_lvl_r;
    conv_req.start  = 1'b0;
    conv_req.number = item.number;

    if (take) begin
      if (item.op == ssdd_pkg::OP_LOAD) begin
        if (st_r == S_IDLE) begin
          conv_req.start = 1'b1;
          st_nxt         = S_START_A;
          tick_nxt       = '0;
          sub_nxt        = '0;
          bit_idx_nxt    = '0;
          dig_nxt        = '0;
        end
      end else begin
        unique case (st_r)
          S_IDLE: begin
          end
          S_START_A, S_START_B, S_START_C: begin
            if (!tick_r[0]) begin
              clk_lvl_nxt = 1'b1;
              dat_lvl_nxt = 1'b1;
              tick_nxt    = tick_r + 5'd1;
            end else begin
              clk_lvl_nxt = 1'b0;
              dat_lvl_nxt = 1'b0;
              st_nxt      = follow;
              tick_nxt    = '0;
            end
          end
          S_STOP_A, S_STOP_B: begin
            if (!tick_r[0]) begin
              clk_lvl_nxt = 1'b0;
              dat_lvl_nxt = 1'b0;
              tick_nxt    = tick_r + 5'd1;
            end else begin
              clk_lvl_nxt = 1'b1;
              dat_lvl_nxt = 1'b1;
              st_nxt      = follow;
              tick_nxt    = '0;
            end
          end
          S_BRIGHT, S_CMD_DATA, S_CMD_ADDR, S_DIGITS: begin
            if (tick_r < ssdd_pkg::BYTE_BIT_TICKS) begin
              // Each bit: clock low, data set, clock high.
              case (sub_r)
                2'd0:    clk_lvl_nxt = 1'b0;
                2'd1:    dat_lvl_nxt = byte_val[bit_idx_r];
                default: begin
                  clk_lvl_nxt = 1'b1;
                  bit_idx_nxt = bit_idx_r + 3'd1;
                end
              endcase
              sub_nxt  = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
              tick_nxt = tick_r + 5'd1;
            end else if (tick_r == ssdd_pkg::BYTE_BIT_TICKS) begin
              clk_lvl_nxt = 1'b0;
              tick_nxt    = tick_r + 5'd1;
            end else begin
              // Closing clock of the byte; the acknowledge slot is not sampled.
              clk_lvl_nxt = 1'b1;
              st_nxt      = follow;
              tick_nxt    = '0;
              sub_nxt     = '0;
              bit_idx_nxt = '0;
              if (st_r == S_DIGITS && !seg_done) begin
                dig_nxt = dig_r + DW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    new_res.clock_pin = clk_lvl_nxt;
    new_res.data_pin  = dat_lvl_nxt;
    new_res.busy      = (st_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      tick_r    <= '0;
      sub_r     <= '0;
      bit_idx_r <= '0;
      dig_r     <= '0;
      clk_lvl_r <= 1'b1;
      dat_lvl_r <= 1'b1;
    end else begin
      st_r      <= st_nxt;
      tick_r    <= tick_nxt;
      sub_r     <= sub_nxt;
      bit_idx_r <= bit_idx_nxt;
      dig_r     <= dig_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (res_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, take} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q_r[wr_ptr_r] <= new_res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/seven_segment_serial_display_driver_core.sv =====
// ----------------------------------------------------------------------------
// Seven-segment serial display driver core
// Converts a number to segment patterns and plays out the two-wire
// clock/data sequence of a multi-digit seven-segment display, one pin
// state per tick transaction.
// ----------------------------------------------------------------------------
// Every input transaction returns exactly one result transaction holding the
// clock and data pin levels after that item plus a busy flag. A load item
// (command 1) that arrives while idle captures the number, displayed modulo
// 10**DIGIT_COUNT, and starts a transfer; a load while busy is ignored. Each
// tick item (command 0) advances the pin sequence by one slot: start, the
// brightness byte, start, 0x40, stop, start, 0xC0, one segment byte per
// digit, stop, for 88 + 26 * DIGIT_COUNT ticks in total. Bytes go out LSB
// first with a ninth closing clock and no acknowledge sampling. The block
// sustains one transaction per clock while results are popped; a result
// passes through the input queue register and then the result queue
// register before it shows on the result ports and can be popped. The
// decimal split of a loaded number runs in the background, one digit per
// clock, long before the digit bytes go out.
// The brightness register may be written only while the block is idle and
// all results have been taken; it is read live while its byte is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_display_driver_core #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input transactions.
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_command,
  input  wire logic [ssdd_pkg::NUMBER_W-1:0] in_number,
  // Result transactions.
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_clock_pin,
  output logic                               out_data_pin,
  output logic                               out_busy_res,
  // Brightness register write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_brightness_command
);

  logic [7:0]                  brightness_val_r;
  logic                        item_valid;
  logic                        item_ready;
  ssdd_pkg::item_t             item;
  ssdd_pkg::conv_req_t         conv_req;
  ssdd_pkg::result_t           result;
  logic [DIGIT_COUNT-1:0][7:0] seg;

  // The register is a plain flop, so writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_val_r <= ssdd_pkg::BRIGHTNESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brightness_val_r <= cfg_brightness_command;
    end
  end

  // Front end: accept and tag input transactions.
  ssdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_number  (in_number),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  // Background decimal split into segment patterns.
  ssdd_digits #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .seg   (seg)
  );

  // Back end: pin sequencer and result queue.
  ssdd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .brightness (brightness_val_r),
    .seg        (seg),
    .conv_req   (conv_req),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .result     (result)
  );

  assign out_clock_pin = result.clock_pin;
  assign out_data_pin  = result.data_pin;
  assign out_busy_res  = result.busy;

endmodule

`default_nettype wire

// ===== sv/ssdd_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the display driver over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic out_clock_pin,
  input wire logic out_data_pin,
  input wire logic out_busy_res
);

  // No result is waiting in the first cycle after reset is released.
  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> out_empty)
    else $error("result queue not empty after reset");

  // An idle result always leaves both lines released high.
  a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_busy_res) |-> (out_clock_pin && out_data_pin))
    else $error("idle result with a line driven low");

  // A waiting result that is not taken stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_clock_pin) && $stable(out_data_pin)
       && $stable(out_busy_res)))
    else $error("waiting result changed before it was taken");

endmodule

bind seven_segment_serial_display_driver_core ssdd_checker u_ssdd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_clock_pin (out_clock_pin),
  .out_data_pin  (out_data_pin),
  .out_busy_res  (out_busy_res)
);

`default_nettype wire
